FILE: design/vpa_pkg.sv
// Package for the variable partition allocator: sizes, request and status
// codes, and the transaction structs. No dependencies.
`default_nettype none
package vpa_pkg;
    localparam int POOL_UNITS  = 128;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_ALLOCATED  = 3'd0;
    localparam logic [2:0] ST_FREED      = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd2;
    localparam logic [2:0] ST_NO_FIT     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;

    localparam logic       KIND_ALLOC = 1'b0;
    localparam logic       KIND_FREE  = 1'b1;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] request_size;
        logic [1:0] strategy;
        logic [15:0] owner_to_free;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] owner_given;
        logic [6:0]  block_start;
    } rsp_t;

    // one table entry as stored
    typedef struct packed {
        logic [6:0]  start;
        logic [7:0]  len;
        logic        free;
        logic [15:0] owner;
    } ent_t;
endpackage
`default_nettype wire

FILE: design/variable_partition_allocator_top.sv
// Variable partition allocator top level: block table in one synchronous
// memory, scanned and shifted by a sequencer. Depends on vpa_pkg.
//
//  channel | ports                  | handshake
//  request | start, busy, req       | accepted when start && !busy
//  result  | done, rsp              | one-cycle strobe, no stall
//
// Sequence after acceptance: a read step and a compare step per entry
// scanned, then a decide step; a split shifts entries up with a read and a
// write step each, then writes the split-off and picked entries; a free reads
// the successor, writes one merge and shifts entries down with a read and
// a write step each. A zero allocation size goes straight to done. After
// reset the table is already valid: entry 0 reads as the whole pool until
// first written, no clear pass. busy stays high from acceptance through the done cycle.
`default_nettype none
module variable_partition_allocator_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire vpa_pkg::req_t req,
    output logic busy,
    output logic done,
    output vpa_pkg::rsp_t rsp
);
    import vpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCANW, S_DECIDE, S_SHUP_RD, S_SHUP_WR,
        S_WR_SPLIT, S_WR_PICK, S_RDA, S_RDB, S_MERGE, S_SHDN_RD, S_SHDN_WR, S_DONE
    } state_t;

    ent_t mem [TABLE_DEPTH];
    ent_t rd_q;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    ent_t wdata;
    logic we;
    logic init_reg;          // entry 0 not yet written: reads as the pool
    logic rd_zero_reg;       // last read addressed entry 0

    state_t state_reg;
    req_t   req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0] next_own_reg;
    logic [CNT_W-1:0] k_reg;       // scan / shift index
    logic found_reg;
    logic [IDX_W-1:0] pick_reg;
    ent_t pick_ent_reg;
    ent_t prev_reg;                // entry before the freed one
    ent_t nb_reg;                  // successor of the freed one
    logic succ_ok_reg;             // nb_reg holds a real successor
    logic [1:0] del_reg;           // entries removed by the shift down
    rsp_t rsp_reg;

    ent_t rd_ent;
    assign rd_ent = (init_reg && rd_zero_reg) ?
        ent_t'{7'd0, 8'(POOL_UNITS), 1'b1, 16'd0} : rd_q;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[raddr];
    end

    logic hit_alloc, hit_free, better;
    assign hit_alloc = rd_ent.free && (rd_ent.len >= req_reg.request_size);
    assign hit_free  = !rd_ent.free && (rd_ent.owner == req_reg.owner_to_free);
    always_comb
    begin
        better = 1'b0;
        if (req_reg.strategy == STRAT_BEST)
            better = rd_ent.len < pick_ent_reg.len;
        else if (req_reg.strategy == STRAT_WORST)
            better = rd_ent.len > pick_ent_reg.len;
    end
    logic multi;
    assign multi = (req_reg.strategy == STRAT_BEST) || (req_reg.strategy == STRAT_WORST);

    logic [CNT_W-1:0] pick_ext;
    assign pick_ext = CNT_W'(pick_reg);

    logic split;
    assign split = (pick_ent_reg.len != req_reg.request_size);

    // entries written at the end of an allocation
    ent_t split_ent, pick_wr_ent;
    assign split_ent = ent_t'{7'(pick_ent_reg.start + req_reg.request_size),
                              8'(pick_ent_reg.len - req_reg.request_size), 1'b1, 16'd0};
    assign pick_wr_ent = ent_t'{pick_ent_reg.start, req_reg.request_size, 1'b0,
                                rsp_reg.owner_given};

    // merge of a freed entry: successor first, then predecessor
    logic succ_free, prev_free;
    logic [IDX_W-1:0] mrg_addr;
    ent_t mrg_ent;
    logic [CNT_W-1:0] mrg_src;
    logic [1:0] mrg_del;
    assign succ_free = succ_ok_reg && nb_reg.free;
    assign prev_free = (pick_reg != '0) && prev_reg.free;
    always_comb
    begin
        mrg_addr = pick_reg;
        mrg_ent = ent_t'{pick_ent_reg.start, pick_ent_reg.len, 1'b1, 16'd0};
        mrg_src = pick_ext;
        mrg_del = 2'd0;
        if (prev_free && succ_free)
        begin
            mrg_addr = IDX_W'(pick_reg - 1'b1);
            mrg_ent = ent_t'{prev_reg.start,
                             8'(prev_reg.len + pick_ent_reg.len + nb_reg.len), 1'b1, 16'd0};
            mrg_src = CNT_W'(pick_ext + 2'd2);
            mrg_del = 2'd2;
        end
        else if (succ_free)
        begin
            mrg_ent = ent_t'{pick_ent_reg.start, 8'(pick_ent_reg.len + nb_reg.len),
                             1'b1, 16'd0};
            mrg_src = CNT_W'(pick_ext + 2'd2);
            mrg_del = 2'd1;
        end
        else if (prev_free)
        begin
            mrg_addr = IDX_W'(pick_reg - 1'b1);
            mrg_ent = ent_t'{prev_reg.start, 8'(prev_reg.len + pick_ent_reg.len),
                             1'b1, 16'd0};
            mrg_src = CNT_W'(pick_ext + 1'b1);
            mrg_del = 2'd1;
        end
    end

    // raddr / write controls are combinational from state
    always_comb
    begin
        raddr = k_reg[IDX_W-1:0];
        we = 1'b0;
        waddr = k_reg[IDX_W-1:0];
        wdata = rd_ent;
        case (state_reg)
            S_SHUP_WR:
            begin
                we = 1'b1;
                waddr = IDX_W'(k_reg + 1'b1);
            end
            S_WR_SPLIT:
            begin
                we = 1'b1;
                waddr = IDX_W'(pick_ext + 1'b1);
                wdata = split_ent;
            end
            S_WR_PICK:
            begin
                we = 1'b1;
                waddr = pick_reg;
                wdata = pick_wr_ent;
            end
            S_MERGE:
            begin
                we = 1'b1;
                waddr = mrg_addr;
                wdata = mrg_ent;
            end
            S_SHDN_WR:
            begin
                we = 1'b1;
                waddr = IDX_W'(k_reg - CNT_W'(del_reg));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg <= '0;
            count_reg <= CNT_W'(1);
            next_own_reg <= 16'd1;
            init_reg <= 1'b1;
            rd_zero_reg <= 1'b0;
            k_reg <= '0;
            found_reg <= 1'b0;
            pick_reg <= '0;
            pick_ent_reg <= '0;
            prev_reg <= '0;
            nb_reg <= '0;
            succ_ok_reg <= 1'b0;
            del_reg <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            rd_zero_reg <= (raddr == '0);
            if (we && waddr == '0)
                init_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        req_reg <= req;
                        k_reg <= '0;
                        found_reg <= 1'b0;
                        if (req.kind == KIND_ALLOC && req.request_size == 8'd0)
                        begin
                            rsp_reg <= rsp_t'{ST_BAD_SIZE, 16'd0, 7'd0};
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_SCANW;
                    end
                S_SCANW:
                    state_reg <= S_SCAN;   // read of k in flight
                S_SCAN:
                begin
                    // rd_ent holds entry k_reg
                    if (req_reg.kind == KIND_ALLOC)
                    begin
                        if (hit_alloc && (!found_reg || better))
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= k_reg[IDX_W-1:0];
                            pick_ent_reg <= rd_ent;
                        end
                        if ((hit_alloc && !found_reg && !multi) || k_reg + 1'b1 >= count_reg)
                            state_reg <= S_DECIDE;
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_SCANW;
                        end
                    end
                    else
                    begin
                        if (hit_free)
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= k_reg[IDX_W-1:0];
                            pick_ent_reg <= rd_ent;
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            prev_reg <= rd_ent;
                            if (k_reg + 1'b1 >= count_reg)
                                state_reg <= S_DECIDE;
                            else
                            begin
                                k_reg <= k_reg + 1'b1;
                                state_reg <= S_SCANW;
                            end
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (!found_reg)
                    begin
                        rsp_reg <= rsp_t'{(req_reg.kind == KIND_FREE) ? ST_NOT_FOUND :
                                          ST_NO_FIT, 16'd0, 7'd0};
                        state_reg <= S_DONE;
                    end
                    else if (req_reg.kind == KIND_ALLOC)
                    begin
                        if (split && count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            rsp_reg <= rsp_t'{ST_TABLE_FULL, 16'd0, 7'd0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            rsp_reg <= rsp_t'{ST_ALLOCATED, next_own_reg,
                                              pick_ent_reg.start};
                            next_own_reg <= (next_own_reg == 16'hFFFF) ? 16'd1 :
                                            next_own_reg + 16'd1;
                            if (split)
                            begin
                                k_reg <= count_reg - 1'b1;
                                count_reg <= count_reg + 1'b1;
                                state_reg <= S_SHUP_RD;
                            end
                            else
                                state_reg <= S_WR_PICK;
                        end
                    end
                    else
                    begin
                        rsp_reg <= rsp_t'{ST_FREED, 16'd0, pick_ent_reg.start};
                        k_reg <= pick_ext + 1'b1;
                        succ_ok_reg <= 1'b0;
                        state_reg <= (pick_ext + 1'b1 < count_reg) ? S_RDA : S_MERGE;
                    end
                end
                // shift entries pick+1..count-1 up by one, top down
                S_SHUP_RD:
                    if (k_reg <= pick_ext)
                        state_reg <= S_WR_SPLIT;
                    else
                        state_reg <= S_SHUP_WR;
                S_SHUP_WR:
                begin
                    k_reg <= k_reg - 1'b1;
                    state_reg <= S_SHUP_RD;
                end
                S_WR_SPLIT:
                    state_reg <= S_WR_PICK;
                S_WR_PICK:
                    state_reg <= S_DONE;
                S_RDA:
                    state_reg <= S_RDB;   // successor read in flight
                S_RDB:
                begin
                    nb_reg <= rd_ent;
                    succ_ok_reg <= 1'b1;
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                    if (mrg_del == 2'd0)
                        state_reg <= S_DONE;
                    else
                    begin
                        del_reg <= mrg_del;
                        k_reg <= mrg_src;
                        if (mrg_src < count_reg)
                            state_reg <= S_SHDN_RD;
                        else
                        begin
                            count_reg <= count_reg - CNT_W'(mrg_del);
                            state_reg <= S_DONE;
                        end
                    end
                // move entries from mrg_src upward down by del_reg
                S_SHDN_RD:
                    state_reg <= S_SHDN_WR;
                S_SHDN_WR:
                    if (k_reg + 1'b1 >= count_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(del_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_SHDN_RD;
                    end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp  = rsp_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy);
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done);
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status <= ST_TABLE_FULL));
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(TABLE_DEPTH)));
endmodule
`default_nettype wire
